@@ rtl/dmc_pkg.sv @@
package dmc_pkg;

    localparam int ADDR_W = 10;
    localparam int DATA_W = 32;
    localparam int CMD_W  = 2;

    localparam int CACHE_WORDS_DEF = 64;
    localparam int BLOCK_WORDS_DEF = 4;
    localparam int MEM_WORDS_DEF   = 1024;

    localparam logic [CMD_W-1:0] CMD_READ   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REPORT = 2'd2;

endpackage

@@ rtl/direct_mapped_cache_unit.sv @@
// Direct-mapped write-through, write-allocate cache with its own backing memory. After reset
// the block sweeps the backing memory and the tag store, one entry a cycle, and takes no
// request until that pass ends. A read hit, a write hit and a report go through one tag and
// data lookup in synchronous memory, started at acceptance, and then a decision state that
// loads the result once the output register is free. A read or write miss goes on to a line
// fill, in which the single read port of the backing memory delivers one word of the line
// per cycle. One request is in flight at a time; the next one is accepted in the cycle after
// the result is loaded into the output register, even while that result still waits to be
// taken. All three sizes must be powers of two.
module direct_mapped_cache_unit #(
    parameter int CACHE_WORDS = dmc_pkg::CACHE_WORDS_DEF,
    parameter int BLOCK_WORDS = dmc_pkg::BLOCK_WORDS_DEF,
    parameter int MEM_WORDS   = dmc_pkg::MEM_WORDS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [dmc_pkg::CMD_W-1:0]         s_cmd,
    input  logic [dmc_pkg::ADDR_W-1:0]        s_address,
    input  logic signed [dmc_pkg::DATA_W-1:0] s_write_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [dmc_pkg::DATA_W-1:0] m_read_data,
    output logic                              m_was_hit,
    output logic [dmc_pkg::DATA_W-1:0]        m_hit_count,
    output logic [dmc_pkg::DATA_W-1:0]        m_miss_count
);

    localparam int ADDR_W  = dmc_pkg::ADDR_W;
    localparam int DATA_W  = dmc_pkg::DATA_W;
    localparam int CMD_W   = dmc_pkg::CMD_W;
    localparam int CW_LOG  = $clog2(CACHE_WORDS);
    localparam int BW_LOG  = $clog2(BLOCK_WORDS);
    localparam int MEM_AW  = $clog2(MEM_WORDS);
    localparam int OFF_LOG = (CW_LOG < BW_LOG) ? CW_LOG : BW_LOG;
    localparam int OFF_W   = (OFF_LOG > 0) ? OFF_LOG : 1;
    localparam int BW_W    = (BW_LOG > 0) ? BW_LOG : 1;
    localparam int LINES   = (CACHE_WORDS >= BLOCK_WORDS) ? CACHE_WORDS / BLOCK_WORDS : 1;
    localparam int IDX_LOG = (CW_LOG > BW_LOG) ? CW_LOG - BW_LOG : 0;
    localparam int IDX_W   = (IDX_LOG > 0) ? IDX_LOG : 1;
    localparam int TAG_LOG = (ADDR_W > CW_LOG) ? ADDR_W - CW_LOG : 0;
    localparam int TAG_W   = (TAG_LOG > 0) ? TAG_LOG : 1;
    localparam int SLOTS   = LINES * BLOCK_WORDS;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FILL_W  = BW_LOG + 1;
    localparam int SUM_W   = ((MEM_AW > ADDR_W) ? MEM_AW : ADDR_W) + 1;
    localparam int CLR_DEPTH = (MEM_WORDS > LINES) ? MEM_WORDS : LINES;
    localparam int CLR_W   = $clog2(CLR_DEPTH);

    localparam logic [ADDR_W-1:0] ADDR_MASK = (MEM_AW >= ADDR_W) ? {ADDR_W{1'b1}}
                                            : ADDR_W'((32'd1 << MEM_AW) - 32'd1);
    localparam logic [ADDR_W-1:0] OFF_MASK  = ADDR_W'((32'd1 << OFF_LOG) - 32'd1);
    localparam logic [ADDR_W-1:0] IDX_MASK  = ADDR_W'((32'd1 << IDX_LOG) - 32'd1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(BLOCK_WORDS);
    localparam logic [CLR_W-1:0]  CLR_LAST  = CLR_W'(CLR_DEPTH - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_FILL
    } state_t;

    state_t             state_reg, state_next;
    logic [CLR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [FILL_W-1:0]  fill_cnt_reg, fill_cnt_next;
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [DATA_W-1:0]  wval_reg, wval_next;
    logic [DATA_W-1:0]  word_reg, word_next;
    logic [DATA_W-1:0]  hits_reg, hits_next;
    logic [DATA_W-1:0]  misses_reg, misses_next;
    logic               m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]  m_read_data_reg, m_read_data_next;
    logic               m_was_hit_reg, m_was_hit_next;
    logic [DATA_W-1:0]  m_hit_count_reg, m_hit_count_next;
    logic [DATA_W-1:0]  m_miss_count_reg, m_miss_count_next;

    logic [ADDR_W-1:0]  cur_addr;
    logic [ADDR_W-1:0]  cur_base;
    logic [TAG_W-1:0]   cur_tag;
    logic [IDX_W-1:0]   cur_idx;
    logic [OFF_W-1:0]   cur_off;
    logic [SLOT_W-1:0]  cur_slot;
    logic [BW_W-1:0]    fill_word;
    logic [SLOT_W-1:0]  fill_slot;
    logic               fill_is_off;
    logic [DATA_W-1:0]  fill_data;
    logic               hit;
    logic               out_free;

    logic               tag_we, tag_re;
    logic [IDX_W-1:0]   tag_waddr;
    logic [TAG_W:0]     tag_wdata, tag_rdata;
    logic               line_we, line_re;
    logic [SLOT_W-1:0]  line_waddr;
    logic [DATA_W-1:0]  line_wdata, line_rdata;
    logic               mem_we, mem_re;
    logic [MEM_AW-1:0]  mem_waddr, mem_raddr;
    logic [DATA_W-1:0]  mem_wdata, mem_rdata;

    // address split, taken from the port while idle so the lookup starts at acceptance
    assign cur_addr = (state_reg == S_IDLE) ? (s_address & ADDR_MASK) : addr_reg;
    assign cur_base = cur_addr & ~OFF_MASK;
    assign cur_tag  = TAG_W'(cur_addr >> CW_LOG);
    assign cur_idx  = IDX_W'((cur_addr >> BW_LOG) & IDX_MASK);
    assign cur_off  = OFF_W'(cur_addr & OFF_MASK);
    assign cur_slot = (SLOT_W'(cur_idx) << BW_LOG) | SLOT_W'(cur_off);

    assign fill_word   = BW_W'(fill_cnt_reg - FILL_W'(1));
    assign fill_slot   = (SLOT_W'(cur_idx) << BW_LOG) | SLOT_W'(fill_word);
    assign fill_is_off = (BW_W'(cur_off) == fill_word);
    assign fill_data   = (cmd_reg == dmc_pkg::CMD_WRITE && fill_is_off) ? wval_reg : mem_rdata;
    assign mem_raddr   = MEM_AW'(SUM_W'(cur_base) + SUM_W'(fill_cnt_reg));

    assign hit      = tag_rdata[TAG_W] && (tag_rdata[TAG_W-1:0] == cur_tag);
    assign out_free = !m_valid_reg || m_ready;

    dmc_ram #(.DEPTH(LINES), .WIDTH(TAG_W + 1)) u_tag_ram (
        .aclk    (aclk),
        .wr_en   (tag_we),
        .wr_addr (tag_waddr),
        .wr_data (tag_wdata),
        .rd_en   (tag_re),
        .rd_addr (cur_idx),
        .rd_data (tag_rdata)
    );

    dmc_ram #(.DEPTH(SLOTS), .WIDTH(DATA_W)) u_line_ram (
        .aclk    (aclk),
        .wr_en   (line_we),
        .wr_addr (line_waddr),
        .wr_data (line_wdata),
        .rd_en   (line_re),
        .rd_addr (cur_slot),
        .rd_data (line_rdata)
    );

    dmc_ram #(.DEPTH(MEM_WORDS), .WIDTH(DATA_W)) u_backing_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    always_comb begin
        state_next        = state_reg;
        clr_cnt_next      = clr_cnt_reg;
        fill_cnt_next     = fill_cnt_reg;
        cmd_next          = cmd_reg;
        addr_next         = addr_reg;
        wval_next         = wval_reg;
        word_next         = word_reg;
        hits_next         = hits_reg;
        misses_next       = misses_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_read_data_next  = m_read_data_reg;
        m_was_hit_next    = m_was_hit_reg;
        m_hit_count_next  = m_hit_count_reg;
        m_miss_count_next = m_miss_count_reg;

        tag_we     = 1'b0;
        tag_re     = 1'b0;
        tag_waddr  = cur_idx;
        tag_wdata  = {1'b1, cur_tag};
        line_we    = 1'b0;
        line_re    = 1'b0;
        line_waddr = cur_slot;
        line_wdata = wval_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = MEM_AW'(cur_addr);
        mem_wdata  = wval_reg;

        unique case (state_reg)
            S_CLEAR: begin
                tag_we    = 1'b1;
                tag_waddr = IDX_W'(clr_cnt_reg);
                tag_wdata = '0;
                mem_we    = 1'b1;
                mem_waddr = MEM_AW'(clr_cnt_reg);
                mem_wdata = '0;
                if (clr_cnt_reg == CLR_LAST) begin
                    state_next = S_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + CLR_W'(1);
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_cmd;
                    addr_next  = cur_addr;
                    wval_next  = s_write_value;
                    tag_re     = 1'b1;
                    line_re    = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (cmd_reg == dmc_pkg::CMD_READ || cmd_reg == dmc_pkg::CMD_WRITE) begin
                    if (!hit) begin
                        mem_re        = 1'b1;
                        fill_cnt_next = FILL_W'(1);
                        state_next    = S_FILL;
                    end else if (out_free) begin
                        m_valid_next      = 1'b1;
                        m_hit_count_next  = '0;
                        m_miss_count_next = '0;
                        if (cmd_reg == dmc_pkg::CMD_READ) begin
                            m_read_data_next = line_rdata;
                            m_was_hit_next   = 1'b1;
                            hits_next        = hits_reg + DATA_W'(hits_reg != '1);
                        end else begin
                            m_read_data_next = '0;
                            m_was_hit_next   = 1'b0;
                            line_we          = 1'b1;
                            mem_we           = 1'b1;
                        end
                        state_next = S_IDLE;
                    end
                end else if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_read_data_next = '0;
                    m_was_hit_next   = 1'b0;
                    if (cmd_reg == dmc_pkg::CMD_REPORT) begin
                        m_hit_count_next  = hits_reg;
                        m_miss_count_next = misses_reg;
                        hits_next         = '0;
                        misses_next       = '0;
                    end else begin
                        m_hit_count_next  = '0;
                        m_miss_count_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            S_FILL: begin
                line_waddr = fill_slot;
                line_wdata = fill_data;
                if (fill_cnt_reg != FILL_FULL) begin
                    line_we       = 1'b1;
                    mem_re        = 1'b1;
                    fill_cnt_next = fill_cnt_reg + FILL_W'(1);
                    if (fill_is_off) begin
                        word_next = fill_data;
                    end
                end else if (out_free) begin
                    line_we           = 1'b1;
                    tag_we            = 1'b1;
                    fill_cnt_next     = '0;
                    m_valid_next      = 1'b1;
                    m_was_hit_next    = 1'b0;
                    m_hit_count_next  = '0;
                    m_miss_count_next = '0;
                    if (cmd_reg == dmc_pkg::CMD_WRITE) begin
                        mem_we           = 1'b1;
                        m_read_data_next = '0;
                    end else begin
                        m_read_data_next = fill_is_off ? mem_rdata : word_reg;
                        misses_next      = misses_reg + DATA_W'(misses_reg != '1);
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            fill_cnt_reg <= '0;
            hits_reg     <= '0;
            misses_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            fill_cnt_reg <= fill_cnt_next;
            hits_reg     <= hits_next;
            misses_reg   <= misses_next;
            m_valid_reg  <= m_valid_next;
        end
        cmd_reg          <= cmd_next;
        addr_reg         <= addr_next;
        wval_reg         <= wval_next;
        word_reg         <= word_next;
        m_read_data_reg  <= m_read_data_next;
        m_was_hit_reg    <= m_was_hit_next;
        m_hit_count_reg  <= m_hit_count_next;
        m_miss_count_reg <= m_miss_count_next;
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_read_data  = m_read_data_reg;
    assign m_was_hit    = m_was_hit_reg;
    assign m_hit_count  = m_hit_count_reg;
    assign m_miss_count = m_miss_count_reg;

    // a new result only ever comes out of a lookup or a line fill
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_next && !(m_valid_reg && !m_ready)) |=>
            ($past(state_reg) == S_LOOKUP || $past(state_reg) == S_FILL))
        else $error("result loaded outside lookup or fill");

    // the fill counter stays within one line
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FILL) |-> (fill_cnt_reg != '0 && fill_cnt_reg <= FILL_FULL))
        else $error("fill counter out of range");

    // a hit result carries no statistics
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_was_hit) |-> (m_hit_count == '0 && m_miss_count == '0))
        else $error("hit result with statistics");

    // no result is produced during the clearing pass
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |=> !m_valid_reg || $past(m_valid_reg))
        else $error("result produced during clearing pass");

endmodule

@@ rtl/dmc_ram.sv @@
module dmc_ram #(
    parameter int DEPTH = dmc_pkg::MEM_WORDS_DEF,
    parameter int WIDTH = dmc_pkg::DATA_W,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
